/* src/cia_pkg.sv */
// Shared types and constants for the check-in interval averager.
package cia_pkg;

	localparam int DATA_W     = 16;
	localparam int ATTEMPT_W  = 8;
	localparam int PROD_W     = DATA_W + ATTEMPT_W;
	localparam int DIVISOR_W  = 8;
	localparam int CFG_ADDR_W = 2;

	localparam int RING_DEPTH_DEF = 8;

	localparam logic [DATA_W-1:0]    BASE_RST      = 16'd40;
	localparam logic [DATA_W-1:0]    AT_LIMIT_RST  = 16'd600;
	localparam logic [ATTEMPT_W-1:0] LIMIT_RST     = 8'd6;
	localparam logic [DATA_W-1:0]    MIN_RST       = 16'd0;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BASE     = 2'd0,
		REG_AT_LIMIT = 2'd1,
		REG_LIMIT    = 2'd2,
		REG_MINIMUM  = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_FILL = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAP,
		ST_FILL,
		ST_OUT
	} state_t;

endpackage

/* src/cia_ring.sv */
// Interval ring storage: one write port, one registered read port, per-entry valid bits.
module cia_ring
	import cia_pkg::*;
#(
	parameter int DEPTH = RING_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rd_data_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// An entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

/* src/cia_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
module cia_div
	import cia_pkg::*;
#(
	parameter int DW = PROD_W,
	parameter int VW = DIVISOR_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] q_q;
	logic [VW-1:0] r_q;
	logic [VW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          ge;
	logic [VW:0]   diff;

	assign trial = {r_q, q_q[DW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			r_q   <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[DW-2:0], ge};
			r_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = q_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (r_q < div_q)) else $error("partial remainder not below divisor");

endmodule

/* src/checkin_interval_averager.sv */
// Check-in interval averager: a ring of recent check-in intervals and the sleep time derived
// from them. An add beat maps its attempt count onto an interval, stores it at the write
// slot and advances the slot; a fill beat writes its value into every entry. Each beat
// returns one result, the floor mean of the ring raised to minimum_interval. One item is
// in work at a time. The division by attempt_limit runs on a bit-serial divider of 24
// bits, one quotient bit per cycle; the mean divides the running sum by RING_DEPTH through
// a multiply by a constant reciprocal. An add starts the divider, waits for its quotient,
// writes the mapped interval at the write slot and then loads its result; a fill writes
// its value into each entry of the ring memory in turn and then loads its result. A
// finished result waits in the output register while the next item is accepted; that
// item then holds in its last state for as long as the output register stays full.
// Configuration writes are always taken.
module checkin_interval_averager
	import cia_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [DATA_W-1:0]     cfg_data,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,  // [7:0] attempt_count, [23:8] fill_value
	input  logic                  s_axis_tuser,  // [0] operation
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [DATA_W-1:0]     m_axis_tdata   // [15:0] next_interval
);

	localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_W = DATA_W + $clog2(RING_DEPTH);

	// floor(sum / RING_DEPTH) == (sum * RECIP_MUL) >> RECIP_SHIFT for every sum below 2**SUM_W
	localparam int     RECIP_SHIFT = SUM_W + $clog2(RING_DEPTH);
	localparam longint RECIP_MUL   = ((longint'(1) << RECIP_SHIFT) + longint'(RING_DEPTH) - 1)
	                                 / longint'(RING_DEPTH);
	localparam int     MEAN_PROD_W = 2 * SUM_W + 1;

	state_t state_q, state_d;

	logic [DATA_W-1:0]    base_q, at_limit_q, min_q;
	logic [ATTEMPT_W-1:0] limit_q;

	logic [DATA_W-1:0] fill_q;
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]  sum_q;
	logic [AW-1:0]     slot_q;
	logic [AW-1:0]     fill_idx_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;

	logic              in_fire;
	logic [DATA_W-1:0] diff;
	logic [DATA_W:0]   mapped_sum;
	logic [DATA_W-1:0] mapped;
	logic [MEAN_PROD_W-1:0] mean_prod;
	logic [DATA_W-1:0] mean_raw;
	logic [DATA_W-1:0] mean;
	logic              fill_last;
	logic              out_load;

	logic              div_start;
	logic [PROD_W-1:0] div_dividend;
	logic [DIVISOR_W-1:0] div_divisor;
	logic              div_busy, div_done;
	logic [PROD_W-1:0] div_quot;

	logic              ring_we, ring_re;
	logic [AW-1:0]     ring_waddr;
	logic [DATA_W-1:0] ring_wdata, ring_rdata;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= BASE_RST;
			at_limit_q <= AT_LIMIT_RST;
			limit_q    <= LIMIT_RST;
			min_q      <= MIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_BASE:     base_q     <= cfg_data;
				REG_AT_LIMIT: at_limit_q <= cfg_data;
				REG_LIMIT:    limit_q    <= cfg_data[ATTEMPT_W-1:0];
				REG_MINIMUM:  min_q      <= cfg_data;
			endcase
		end
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign diff    = (at_limit_q > base_q) ? (at_limit_q - base_q) : '0;

	// Saturate base plus scaled difference at the data width.
	assign mapped_sum = {1'b0, base_q} + {1'b0, div_quot[DATA_W-1:0]};
	assign mapped     = ((|div_quot[PROD_W-1:DATA_W]) || mapped_sum[DATA_W]) ?
	                    '1 : mapped_sum[DATA_W-1:0];
	assign mean_prod  = MEAN_PROD_W'(sum_q) * MEAN_PROD_W'(RECIP_MUL);
	assign mean_raw   = mean_prod[RECIP_SHIFT +: DATA_W];
	assign mean       = (mean_raw < min_q) ? min_q : mean_raw;
	assign fill_last  = fill_idx_q == AW'(RING_DEPTH - 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = (op_t'(s_axis_tuser) == OP_FILL) ? ST_FILL : ST_LOAD;
				end
			end
			ST_LOAD:    state_d = ST_MAP;
			ST_MAP:     if (div_done) state_d = ST_OUT;
			ST_FILL:    if (fill_last) state_d = ST_OUT;
			ST_OUT:     if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		div_dividend  = prod_q;
		div_divisor   = (limit_q == '0) ? DIVISOR_W'(1) : DIVISOR_W'(limit_q);
		ring_re       = 1'b0;
		ring_we       = 1'b0;
		ring_waddr    = slot_q;
		ring_wdata    = mapped;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				ring_re       = in_fire && (op_t'(s_axis_tuser) == OP_ADD);
			end
			ST_LOAD: begin
				div_start = 1'b1;
			end
			ST_MAP: begin
				ring_we = div_done;
			end
			ST_FILL: begin
				ring_we    = 1'b1;
				ring_waddr = fill_idx_q;
				ring_wdata = fill_q;
			end
			ST_OUT: begin
				out_load = !out_valid_q || m_axis_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			fill_q <= s_axis_tdata[23:8];
			prod_q <= PROD_W'(diff) * PROD_W'(s_axis_tdata[7:0]);
		end
		if (out_load) begin
			out_data_q <= mean;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			slot_q      <= '0;
			fill_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && (op_t'(s_axis_tuser) == OP_FILL)) begin
				sum_q      <= '0;
				fill_idx_q <= '0;
			end
			if (state_q == ST_FILL) begin
				sum_q      <= sum_q + SUM_W'(fill_q);
				fill_idx_q <= fill_idx_q + 1'b1;
			end
			// Replace the old entry in the running sum and advance the slot.
			if (state_q == ST_MAP && div_done) begin
				sum_q  <= sum_q - SUM_W'(ring_rdata) + SUM_W'(mapped);
				slot_q <= (slot_q == AW'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	cia_div #(
		.DW(PROD_W),
		.VW(DIVISOR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	cia_ring #(
		.DEPTH(RING_DEPTH),
		.AW   (AW)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ring_we),
		.wr_addr (ring_waddr),
		.wr_data (ring_wdata),
		.rd_en   (ring_re),
		.rd_addr (slot_q),
		.rd_data (ring_rdata)
	);

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= AW'(RING_DEPTH - 1)) else $error("write slot beyond ring depth");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_axis_tready) else $error("second beat accepted while one in work");

	a_div_idle_at_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> !div_busy) else $error("divider busy when result is loaded");

endmodule
